@@ rtl/bavg_pkg.sv @@
// ============================================================================
// bavg_pkg: shared types and constants of the block average downsampler
// Field widths, size limits, register indexes and the reciprocal table used
// to turn the tile mean division into a multiplication.
// ============================================================================
package bavg_pkg;

    // Field widths.
    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 23;
    localparam int ROW_W    = 12;
    localparam int COL_W    = 10;
    localparam int COUNT_W  = 7;
    localparam int RECIP_W  = 23;

    // Configuration register widths.
    localparam int ROWS_CFG_W  = 13;
    localparam int COLS_CFG_W  = 11;
    localparam int BLOCK_CFG_W = 4;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 2;

    // Size limits that the register values are clamped to.
    localparam logic [ROWS_CFG_W-1:0]  MAX_ROWS  = 13'd4096;
    localparam logic [COLS_CFG_W-1:0]  MAX_COLS  = 11'd1024;
    localparam logic [BLOCK_CFG_W-1:0] MAX_BLOCK = 4'd8;

    // Depth of the tile sum memory, one entry per output column.
    localparam int SUM_DEPTH = 1024;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FRAME_ROWS   = 2'd0,
        REG_FRAME_COLS   = 2'd1,
        REG_BLOCK_HEIGHT = 2'd2,
        REG_BLOCK_WIDTH  = 2'd3
    } cfg_index_t;

    // Entry n-1 holds floor(2^22 / n), which equals floor(2^23 / (2n)).
    localparam logic [RECIP_W-1:0] RECIP_TABLE [0:63] = '{
        23'd4194304, 23'd2097152, 23'd1398101, 23'd1048576,
        23'd838860,  23'd699050,  23'd599186,  23'd524288,
        23'd466033,  23'd419430,  23'd381300,  23'd349525,
        23'd322638,  23'd299593,  23'd279620,  23'd262144,
        23'd246723,  23'd233016,  23'd220752,  23'd209715,
        23'd199728,  23'd190650,  23'd182361,  23'd174762,
        23'd167772,  23'd161319,  23'd155344,  23'd149796,
        23'd144631,  23'd139810,  23'd135300,  23'd131072,
        23'd127100,  23'd123361,  23'd119837,  23'd116508,
        23'd113359,  23'd110376,  23'd107546,  23'd104857,
        23'd102300,  23'd99864,   23'd97541,   23'd95325,
        23'd93206,   23'd91180,   23'd89240,   23'd87381,
        23'd85598,   23'd83886,   23'd82241,   23'd80659,
        23'd79137,   23'd77672,   23'd76260,   23'd74898,
        23'd73584,   23'd72315,   23'd71089,   23'd69905,
        23'd68759,   23'd67650,   23'd66576,   23'd65536
    };

endpackage

@@ rtl/block_average_downsampler.sv @@
// ============================================================================
// block_average_downsampler: box pooling of a raster sample stream
// Averages non-overlapping tiles of a frame and emits one rounded mean per
// tile, with partial tiles at the right and bottom edges.
// ============================================================================
// The block takes one item per clock cycle; the last sample of a tile carries
// its mean through stages 1 to 4 and the result register. Running tile sums
// live in a 1024-entry synchronous memory, one entry per output column; each
// sample reads its entry in the cycle it is accepted and writes it back from
// stage 1, and a forwarding register covers a sample that follows directly on
// the same entry. The mean is formed by multiplying with a reciprocal from a
// table, with a single correction step. When the result register is full and
// not taken, the whole pipeline holds and the input is not ready. Writing any
// configuration register restarts the frame at row 0, column 0; the memory
// needs no clearing, as the first sample of every tile overwrites its entry.
module block_average_downsampler
(
    input  logic        clk,
    input  logic        rst_n,

    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic [bavg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bavg_pkg::CFG_DATA_W-1:0]  cfg_wdata,

    // Input items.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample
    // Result items.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [15:0] average, [27:16] out_row,
                                        // [37:28] out_col, [39:38] zero
    output logic        m_axis_tlast    // frame_end
);

    // Configuration registers.
    logic [bavg_pkg::ROWS_CFG_W-1:0]  frame_rows_reg;
    logic [bavg_pkg::COLS_CFG_W-1:0]  frame_cols_reg;
    logic [bavg_pkg::BLOCK_CFG_W-1:0] block_height_reg;
    logic [bavg_pkg::BLOCK_CFG_W-1:0] block_width_reg;

    // Clamped sizes.
    logic [bavg_pkg::ROWS_CFG_W-1:0]  rows_eff;
    logic [bavg_pkg::COLS_CFG_W-1:0]  cols_eff;
    logic [bavg_pkg::BLOCK_CFG_W-1:0] bh_eff;
    logic [bavg_pkg::BLOCK_CFG_W-1:0] bw_eff;

    // Raster position counters.
    logic [bavg_pkg::ROW_W-1:0] row_reg;
    logic [bavg_pkg::COL_W-1:0] col_reg;
    logic [2:0]                 rin_reg;
    logic [2:0]                 cin_reg;
    logic [bavg_pkg::ROW_W-1:0] tr_reg;
    logic [bavg_pkg::COL_W-1:0] tc_reg;

    logic advance;
    logic in_accept;
    logic last_col;
    logic last_row;
    logic end_of_cols;
    logic end_of_rows;
    logic first_of_tile;

    // Stage 1: read-modify-write of the tile sum.
    logic                              s1_valid_reg;
    logic signed [bavg_pkg::SAMPLE_W-1:0] s1_sample_reg;
    logic                              s1_first_reg;
    logic                              s1_emit_reg;
    logic [3:0]                        s1_nw_reg;
    logic [3:0]                        s1_nh_reg;
    logic [bavg_pkg::ROW_W-1:0]        s1_tr_reg;
    logic [bavg_pkg::COL_W-1:0]        s1_tc_reg;
    logic                              s1_fe_reg;
    logic signed [bavg_pkg::SUM_W-1:0] rd_data_reg;
    logic                              fwd_hit_reg;
    logic signed [bavg_pkg::SUM_W-1:0] fwd_data_reg;
    logic signed [bavg_pkg::SUM_W-1:0] sum_base;
    logic signed [bavg_pkg::SUM_W-1:0] sum_new;
    logic [7:0]                        count_prod;

    logic signed [bavg_pkg::SUM_W-1:0] sum_mem [0:bavg_pkg::SUM_DEPTH-1];

    // Stage 2: magnitude and numerator.
    logic                              s2_valid_reg;
    logic signed [bavg_pkg::SUM_W-1:0] s2_sum_reg;
    logic [bavg_pkg::COUNT_W-1:0]      s2_n_reg;
    logic [bavg_pkg::ROW_W-1:0]        s2_tr_reg;
    logic [bavg_pkg::COL_W-1:0]        s2_tc_reg;
    logic                              s2_fe_reg;
    logic [bavg_pkg::SUM_W-1:0]        s2_mag_full;
    logic [bavg_pkg::SUM_W-1:0]        s2_numer;

    // Stage 3: reciprocal multiply.
    logic                              s3_valid_reg;
    logic [bavg_pkg::SUM_W-1:0]        s3_numer_reg;
    logic [bavg_pkg::RECIP_W-1:0]      s3_recip_reg;
    logic [bavg_pkg::COUNT_W-1:0]      s3_n_reg;
    logic                              s3_neg_reg;
    logic [bavg_pkg::ROW_W-1:0]        s3_tr_reg;
    logic [bavg_pkg::COL_W-1:0]        s3_tc_reg;
    logic                              s3_fe_reg;
    logic [45:0]                       s3_prod;

    // Stage 4: correction and sign.
    logic                              s4_valid_reg;
    logic [16:0]                       s4_q0_reg;
    logic [bavg_pkg::SUM_W-1:0]        s4_numer_reg;
    logic [bavg_pkg::COUNT_W-1:0]      s4_n_reg;
    logic                              s4_neg_reg;
    logic [bavg_pkg::ROW_W-1:0]        s4_tr_reg;
    logic [bavg_pkg::COL_W-1:0]        s4_tc_reg;
    logic                              s4_fe_reg;
    logic [7:0]                        s4_div;
    logic [24:0]                       s4_qd;
    logic [24:0]                       s4_rem;
    logic [16:0]                       s4_qc;
    logic [16:0]                       s4_signed_q;

    // Result register.
    logic                              out_valid_reg;
    logic [bavg_pkg::SAMPLE_W-1:0]     out_avg_reg;
    logic [bavg_pkg::ROW_W-1:0]        out_row_reg;
    logic [bavg_pkg::COL_W-1:0]        out_col_reg;
    logic                              out_fe_reg;

    // Clamp the size registers: zero acts as one, oversize acts as the limit.
    always_comb
    begin
        rows_eff = (frame_rows_reg == '0) ? 13'd1 :
                   (frame_rows_reg > bavg_pkg::MAX_ROWS) ? bavg_pkg::MAX_ROWS :
                   frame_rows_reg;
        cols_eff = (frame_cols_reg == '0) ? 11'd1 :
                   (frame_cols_reg > bavg_pkg::MAX_COLS) ? bavg_pkg::MAX_COLS :
                   frame_cols_reg;
        bh_eff   = (block_height_reg == '0) ? 4'd1 :
                   (block_height_reg > bavg_pkg::MAX_BLOCK) ? bavg_pkg::MAX_BLOCK :
                   block_height_reg;
        bw_eff   = (block_width_reg == '0) ? 4'd1 :
                   (block_width_reg > bavg_pkg::MAX_BLOCK) ? bavg_pkg::MAX_BLOCK :
                   block_width_reg;
    end

    // The whole pipeline moves unless a held result blocks the output.
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;
    assign in_accept     = s_axis_tvalid && advance;

    // Tile edge detection for the sample at the current position.
    always_comb
    begin
        end_of_cols   = ({1'b0, col_reg} + 11'd1) == cols_eff;
        end_of_rows   = ({1'b0, row_reg} + 13'd1) == rows_eff;
        last_col      = ({1'b0, cin_reg} == bw_eff - 4'd1) || end_of_cols;
        last_row      = ({1'b0, rin_reg} == bh_eff - 4'd1) || end_of_rows;
        first_of_tile = (rin_reg == 3'd0) && (cin_reg == 3'd0);
    end

    // Configuration registers and raster counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_rows_reg   <= 13'd1;
            frame_cols_reg   <= 11'd1;
            block_height_reg <= 4'd2;
            block_width_reg  <= 4'd2;
            row_reg          <= '0;
            col_reg          <= '0;
            rin_reg          <= '0;
            cin_reg          <= '0;
            tr_reg           <= '0;
            tc_reg           <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (bavg_pkg::cfg_index_t'(cfg_index))
                bavg_pkg::REG_FRAME_ROWS:
                    frame_rows_reg <= cfg_wdata[bavg_pkg::ROWS_CFG_W-1:0];
                bavg_pkg::REG_FRAME_COLS:
                    frame_cols_reg <= cfg_wdata[bavg_pkg::COLS_CFG_W-1:0];
                bavg_pkg::REG_BLOCK_HEIGHT:
                    block_height_reg <= cfg_wdata[bavg_pkg::BLOCK_CFG_W-1:0];
                bavg_pkg::REG_BLOCK_WIDTH:
                    block_width_reg <= cfg_wdata[bavg_pkg::BLOCK_CFG_W-1:0];
                default:
                    frame_rows_reg <= frame_rows_reg;
            endcase
            row_reg <= '0;
            col_reg <= '0;
            rin_reg <= '0;
            cin_reg <= '0;
            tr_reg  <= '0;
            tc_reg  <= '0;
        end
        else if (in_accept)
        begin
            if (end_of_cols)
            begin
                col_reg <= '0;
                cin_reg <= '0;
                tc_reg  <= '0;
                if (end_of_rows)
                begin
                    row_reg <= '0;
                    rin_reg <= '0;
                    tr_reg  <= '0;
                end
                else
                begin
                    row_reg <= row_reg + 12'd1;
                    if ({1'b0, rin_reg} == bh_eff - 4'd1)
                    begin
                        rin_reg <= '0;
                        tr_reg  <= tr_reg + 12'd1;
                    end
                    else
                    begin
                        rin_reg <= rin_reg + 3'd1;
                    end
                end
            end
            else
            begin
                col_reg <= col_reg + 10'd1;
                if ({1'b0, cin_reg} == bw_eff - 4'd1)
                begin
                    cin_reg <= '0;
                    tc_reg  <= tc_reg + 10'd1;
                end
                else
                begin
                    cin_reg <= cin_reg + 3'd1;
                end
            end
        end
    end

    // Tile sum memory: read at acceptance, written back from stage 1.
    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            sum_mem[s1_tc_reg] <= sum_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rd_data_reg <= sum_mem[tc_reg];
        end
    end

    // Stage 1 sum: restart on the first sample of a tile, else accumulate.
    always_comb
    begin
        sum_base   = s1_first_reg ? '0 : (fwd_hit_reg ? fwd_data_reg : rd_data_reg);
        sum_new    = sum_base + {{(bavg_pkg::SUM_W - bavg_pkg::SAMPLE_W){s1_sample_reg[15]}},
                                 s1_sample_reg};
        count_prod = s1_nw_reg * s1_nh_reg;
    end

    // Stage 1 control and the forwarding register for back-to-back updates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_accept;
            fwd_hit_reg  <= in_accept && s1_valid_reg && (s1_tc_reg == tc_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_sample_reg <= s_axis_tdata;
            s1_first_reg  <= first_of_tile;
            s1_emit_reg   <= last_col && last_row;
            s1_nw_reg     <= {1'b0, cin_reg} + 4'd1;
            s1_nh_reg     <= {1'b0, rin_reg} + 4'd1;
            s1_tr_reg     <= tr_reg;
            s1_tc_reg     <= tc_reg;
            s1_fe_reg     <= end_of_cols && end_of_rows;
            fwd_data_reg  <= sum_new;
        end
    end

    // Stage 2: magnitude and rounding numerator 2*|sum| + n.
    always_comb
    begin
        s2_mag_full = s2_sum_reg[bavg_pkg::SUM_W-1] ? (23'd0 - s2_sum_reg) : s2_sum_reg;
        s2_numer    = {s2_mag_full[bavg_pkg::SUM_W-2:0], 1'b0} + {16'd0, s2_n_reg};
    end

    // Stage 3: numerator times reciprocal of 2n.
    assign s3_prod = {23'd0, s3_numer_reg} * {23'd0, s3_recip_reg};

    // Stage 4: the estimate is at most one low; fix it and apply the sign.
    always_comb
    begin
        s4_div      = {s4_n_reg, 1'b0};
        s4_qd       = {8'd0, s4_q0_reg} * {17'd0, s4_div};
        s4_rem      = {2'd0, s4_numer_reg} - s4_qd;
        s4_qc       = (s4_rem >= {17'd0, s4_div}) ? (s4_q0_reg + 17'd1) : s4_q0_reg;
        s4_signed_q = s4_neg_reg ? (17'd0 - s4_qc) : s4_qc;
    end

    // Valid flags of the divide pipeline and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg  <= s1_valid_reg && s1_emit_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg;
        end
    end

    // Payload of the divide pipeline and the result register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_sum_reg   <= sum_new;
            s2_n_reg     <= count_prod[bavg_pkg::COUNT_W-1:0];
            s2_tr_reg    <= s1_tr_reg;
            s2_tc_reg    <= s1_tc_reg;
            s2_fe_reg    <= s1_fe_reg;

            s3_numer_reg <= s2_numer;
            s3_recip_reg <= bavg_pkg::RECIP_TABLE[6'(s2_n_reg - 7'd1)];
            s3_n_reg     <= s2_n_reg;
            s3_neg_reg   <= s2_sum_reg[bavg_pkg::SUM_W-1];
            s3_tr_reg    <= s2_tr_reg;
            s3_tc_reg    <= s2_tc_reg;
            s3_fe_reg    <= s2_fe_reg;

            s4_q0_reg    <= s3_prod[39:23];
            s4_numer_reg <= s3_numer_reg;
            s4_n_reg     <= s3_n_reg;
            s4_neg_reg   <= s3_neg_reg;
            s4_tr_reg    <= s3_tr_reg;
            s4_tc_reg    <= s3_tc_reg;
            s4_fe_reg    <= s3_fe_reg;

            out_avg_reg  <= s4_signed_q[bavg_pkg::SAMPLE_W-1:0];
            out_row_reg  <= s4_tr_reg;
            out_col_reg  <= s4_tc_reg;
            out_fe_reg   <= s4_fe_reg;
        end
    end

    // Result port.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_col_reg, out_row_reg, out_avg_reg};
    assign m_axis_tlast  = out_fe_reg;

    // The in-tile column counter never reaches the tile width.
    assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, cin_reg} < bw_eff)
        else $error("column within tile out of range");

    // The raster counters stay inside the frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, col_reg} < cols_eff) && ({1'b0, row_reg} < rows_eff))
        else $error("raster position outside frame");

    // A forwarded sum always belongs to a live stage 1 item.
    assert property (@(posedge clk) disable iff (!rst_n)
        fwd_hit_reg |-> s1_valid_reg)
        else $error("forwarding without a stage 1 item");

    // The corrected mean magnitude never exceeds the sample range.
    assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg |-> (s4_qc <= 17'd32768))
        else $error("tile mean magnitude out of range");

endmodule

@@ tb/sv/block_average_downsampler_checker.sv @@
// ============================================================================
// block_average_downsampler_checker: tile mean predictor and result scoreboard
// Watches the configuration port and both streams of the downsampler. It
// keeps its own copy of the size registers, raster position and running
// tile sums, works out each tile mean, and compares every result item with
// the oldest outstanding mean.
// ============================================================================
module block_average_downsampler_checker
(
    input  logic        clk,
    input  logic        rst_n,

    // Configuration write port, as seen by the block.
    input  logic        cfg_wr_en,
    input  logic [bavg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bavg_pkg::CFG_DATA_W-1:0]  cfg_wdata,

    // Input items.
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample

    // Result items.
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,   // [15:0] average, [27:16] out_row,
                                        // [37:28] out_col, [39:38] zero
    input  logic        m_axis_tlast,   // frame_end

    output int          mismatch_count,
    output int          means_due,
    output int          means_checked
);

    import bavg_pkg::*;

    typedef struct packed {
        logic [SAMPLE_W-1:0] average;
        logic [ROW_W-1:0]    out_row;
        logic [COL_W-1:0]    out_col;
        logic                frame_end;
    } tile_mean_t;

    // Tile means that have been predicted but not yet seen on the output.
    tile_mean_t tile_means_due [$];

    // Shadow of the size registers, as written.
    logic [ROWS_CFG_W-1:0]  rows_reg;
    logic [COLS_CFG_W-1:0]  cols_reg;
    logic [BLOCK_CFG_W-1:0] height_reg;
    logic [BLOCK_CFG_W-1:0] width_reg;

    // Running sums per tile column and the raster position of the next sample.
    int tile_sum [0:SUM_DEPTH-1];
    int row_at;
    int col_at;

    // A size of zero acts as one; sizes above the limit act as the limit.
    function automatic int clamp_size(input int value, input int limit);
        if (value == 0)
            return 1;
        return (value > limit) ? limit : value;
    endfunction

    // Accumulates one sample into its tile and advances the raster position.
    // Returns 1 when the sample closes a tile, with the rounded mean in mean.
    function automatic bit accumulate_sample(input logic [SAMPLE_W-1:0] raw,
                                             output tile_mean_t mean);
        int rows;
        int cols;
        int bh;
        int bw;
        int r;
        int c;
        int tr;
        int tc;
        int slot;
        int count;
        int sum;
        int mag;
        int q;
        int avg;
        bit col_end;
        bit row_end;
        bit emit;

        rows = clamp_size(int'(rows_reg), int'(MAX_ROWS));
        cols = clamp_size(int'(cols_reg), int'(MAX_COLS));
        bh   = clamp_size(int'(height_reg), int'(MAX_BLOCK));
        bw   = clamp_size(int'(width_reg), int'(MAX_BLOCK));

        if (row_at >= rows || col_at >= cols)
        begin
            row_at = 0;
            col_at = 0;
        end
        r    = row_at;
        c    = col_at;
        tr   = r / bh;
        tc   = c / bw;
        slot = tc % SUM_DEPTH;

        // The first sample of a tile starts a new sum.
        if ((r % bh) == 0 && (c % bw) == 0)
            tile_sum[slot] = int'($signed(raw));
        else
            tile_sum[slot] = tile_sum[slot] + int'($signed(raw));

        col_end = ((c % bw) == bw - 1) || (c + 1 == cols);
        row_end = ((r % bh) == bh - 1) || (r + 1 == rows);
        emit    = col_end && row_end;
        mean    = '0;

        if (emit)
        begin
            // Edge tiles hold fewer samples than a full tile.
            count = ((bw < cols - tc * bw) ? bw : cols - tc * bw) *
                    ((bh < rows - tr * bh) ? bh : rows - tr * bh);
            sum   = tile_sum[slot];
            mag   = (sum < 0) ? -sum : sum;
            // Round half away from zero on the magnitude.
            q     = (2 * mag + count) / (2 * count);
            avg   = (sum < 0) ? -q : q;
            mean.average   = avg[SAMPLE_W-1:0];
            mean.out_row   = tr[ROW_W-1:0];
            mean.out_col   = tc[COL_W-1:0];
            mean.frame_end = (c + 1 == cols) && (r + 1 == rows);
        end

        if (c + 1 >= cols)
        begin
            col_at = 0;
            row_at = (r + 1 >= rows) ? 0 : r + 1;
        end
        else
        begin
            col_at = c + 1;
        end
        return emit;
    endfunction

    task automatic report_mismatch(input string what, input logic [39:0] got,
                                   input logic [39:0] wanted);
        $display("[%0t] mismatch on %s: got %0h, expected %0h (result %0d)",
                 $time, what, got, wanted, means_checked);
        mismatch_count++;
    endtask

    // Track the registers, predict on accepted samples, check accepted results.
    always @(posedge clk)
    begin
        tile_mean_t oldest;
        tile_mean_t fresh;

        if (!rst_n)
        begin
            rows_reg   = 1;
            cols_reg   = 1;
            height_reg = 2;
            width_reg  = 2;
            row_at     = 0;
            col_at     = 0;
            tile_means_due.delete();
            mismatch_count = 0;
            means_checked  = 0;
        end
        else
        begin
            // Any register write restarts the frame.
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_FRAME_ROWS:   rows_reg   = cfg_wdata[ROWS_CFG_W-1:0];
                    REG_FRAME_COLS:   cols_reg   = cfg_wdata[COLS_CFG_W-1:0];
                    REG_BLOCK_HEIGHT: height_reg = cfg_wdata[BLOCK_CFG_W-1:0];
                    REG_BLOCK_WIDTH:  width_reg  = cfg_wdata[BLOCK_CFG_W-1:0];
                    default: ;
                endcase
                row_at = 0;
                col_at = 0;
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                if (tile_means_due.size() == 0)
                begin
                    report_mismatch("unexpected result", m_axis_tdata, '0);
                end
                else
                begin
                    oldest = tile_means_due.pop_front();
                    if (m_axis_tdata[15:0] !== oldest.average)
                        report_mismatch("average", m_axis_tdata[15:0], oldest.average);
                    if (m_axis_tdata[27:16] !== oldest.out_row)
                        report_mismatch("out_row", m_axis_tdata[27:16], oldest.out_row);
                    if (m_axis_tdata[37:28] !== oldest.out_col)
                        report_mismatch("out_col", m_axis_tdata[37:28], oldest.out_col);
                    if (m_axis_tdata[39:38] !== 2'b00)
                        report_mismatch("tdata padding", m_axis_tdata[39:38], '0);
                    if (m_axis_tlast !== oldest.frame_end)
                        report_mismatch("frame_end", m_axis_tlast, oldest.frame_end);
                    means_checked++;
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                if (accumulate_sample(s_axis_tdata, fresh))
                    tile_means_due.push_back(fresh);
            end
        end
        means_due = tile_means_due.size();
    end

endmodule

@@ tb/sv/block_average_downsampler_tb.sv @@
// ============================================================================
// block_average_downsampler_tb: stimulus and verdict for the box downsampler
// Drives raster sample streams through a range of frame and tile sizes,
// including zero and oversize register values, with random gaps on the
// input and random stalls on the output. A separate checker predicts and
// compares every tile mean; this module reports the overall result.
// ============================================================================
module block_average_downsampler_tb;

    import bavg_pkg::*;

    localparam int RANDOM_ITEMS = 450;
    localparam int DRAIN_CYCLES = 12;
    localparam int IDLE_LIMIT   = 2000;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;      // [15:0] sample
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;      // [15:0] average, [27:16] out_row,
                                    // [37:28] out_col, [39:38] zero
    logic        m_axis_tlast;      // frame_end

    int mismatch_count;
    int means_due;
    int means_checked;

    // Stimulus bookkeeping.
    int  samples_sent;
    int  ordinary_items;
    int  phase;
    int  eff_rows;
    int  eff_cols;
    bit  sender_calm;

    block_average_downsampler uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    block_average_downsampler_checker checker_i
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast),
        .mismatch_count (mismatch_count),
        .means_due      (means_due),
        .means_checked  (means_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int eff_size(input int value, input int limit);
        if (value == 0)
            return 1;
        return (value > limit) ? limit : value;
    endfunction

    // All tasks below start and end at a falling edge.
    task automatic send_sample(input logic [15:0] value);
        int gap;
        gap = sender_calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = value;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        samples_sent++;
    endtask

    // Hold the input until every outstanding tile mean has come out.
    task automatic hold_for_means();
        s_axis_tvalid = 1'b0;
        while (means_due != 0)
            @(negedge clk);
    endtask

    // Let the pipeline empty, including samples that close no tile.
    task automatic settle();
        hold_for_means();
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t index, input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en = 1'b1;
        cfg_index = index;
        cfg_wdata = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        case (index)
            REG_FRAME_ROWS: eff_rows = eff_size(int'(value), int'(MAX_ROWS));
            REG_FRAME_COLS: eff_cols = eff_size(int'(value[COLS_CFG_W-1:0]),
                                                int'(MAX_COLS));
            default: ;
        endcase
    endtask

    // Whole frames of random samples, optionally followed by a cut-off frame.
    task automatic run_frames(input int frames, input int extra);
        int total;
        int pause_at;
        logic [15:0] value;
        total    = frames * eff_rows * eff_cols + extra;
        pause_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, total - 1) : -1;
        for (int i = 0; i < total; i++)
        begin
            if (i == pause_at)
                hold_for_means();
            if ($urandom_range(0, 7) == 0)
                value = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            else
                value = $urandom_range(0, 65535);
            send_sample(value);
        end
    endtask

    // Random block size value, sometimes zero or oversize, junk in upper bits.
    function automatic logic [CFG_DATA_W-1:0] pick_block();
        int roll;
        logic [CFG_DATA_W-1:0] value;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            value = 0;
        else if (roll == 1)
            value = $urandom_range(9, 15);
        else
            value = $urandom_range(1, 8);
        value[CFG_DATA_W-1:BLOCK_CFG_W] = $urandom_range(0, 511);
        return value;
    endfunction

    // Receiver: random stalls, with occasional long stretches always ready.
    initial
    begin
        int stall;
        m_axis_tready = 1'b1;
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready = 1'b1;
            repeat (($urandom_range(0, 15) == 0) ? $urandom_range(50, 300)
                                                 : $urandom_range(1, 6))
                @(negedge clk);
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                cfg_wr_en || !rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // Main stimulus.
    initial
    begin
        logic [15:0] edge_values [7];
        logic [15:0] tie_tiles [16];
        int frames;
        int extra;
        int mask;
        int roll;
        logic [CFG_DATA_W-1:0] value;

        edge_values = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
                        16'h0001, 16'h5555, 16'hAAAA};
        // Each group of four is one 2x2 tile: +0.5 and -0.5 LSB ties, then
        // the largest and the most negative sample everywhere.
        tie_tiles   = '{16'h0001, 16'h0001, 16'h0000, 16'h0000,
                        16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000,
                        16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                        16'h8000, 16'h8000, 16'h8000, 16'h8000};

        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = REG_FRAME_ROWS;
        cfg_wdata      = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        sender_calm    = 1'b0;
        samples_sent   = 0;
        ordinary_items = 0;
        phase          = 0;
        eff_rows       = 1;
        eff_cols       = 1;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset sizes give a 1x1 frame in a 2x2 tile: each mean is the sample.
        foreach (edge_values[i])
            send_sample(edge_values[i]);
        settle();

        // One full 2x2 tile per frame for rounding ties and range extremes.
        write_reg(REG_FRAME_ROWS, 2);
        write_reg(REG_FRAME_COLS, 2);
        write_reg(REG_BLOCK_HEIGHT, 2);
        write_reg(REG_BLOCK_WIDTH, 2);
        foreach (tie_tiles[i])
            send_sample(tie_tiles[i]);
        settle();

        // Random phases, a few of them pinned to the size extremes.
        while (ordinary_items < RANDOM_ITEMS || phase < 10)
        begin
            phase++;
            sender_calm = ($urandom_range(0, 4) == 0);
            if (phase == 3)
            begin
                // Tallest frame, one column: out_row runs up to its top value.
                write_reg(REG_FRAME_ROWS, 13'h1FFF);
                write_reg(REG_FRAME_COLS, 0);
                write_reg(REG_BLOCK_HEIGHT, 0);
                write_reg(REG_BLOCK_WIDTH, 13'h0FF9);
                run_frames(1, 0);
            end
            else if (phase == 6)
            begin
                // Widest frame with one-column tiles: every sum entry in use.
                write_reg(REG_FRAME_ROWS, 2);
                write_reg(REG_FRAME_COLS, 13'h1FFF);
                write_reg(REG_BLOCK_HEIGHT, 2);
                write_reg(REG_BLOCK_WIDTH, 1);
                run_frames(1, 0);
            end
            else if (phase == 9)
            begin
                // Largest tiles with partial tiles on both edges.
                write_reg(REG_FRAME_ROWS, 17);
                write_reg(REG_FRAME_COLS, 19);
                write_reg(REG_BLOCK_HEIGHT, 8);
                write_reg(REG_BLOCK_WIDTH, 8);
                run_frames(2, 0);
            end
            else
            begin
                mask = $urandom_range(1, 15);
                if (mask[0])
                begin
                    roll  = $urandom_range(0, 9);
                    value = (roll == 0) ? 0 :
                            (roll == 1) ? $urandom_range(13, 30) : $urandom_range(1, 12);
                    write_reg(REG_FRAME_ROWS, value);
                end
                if (mask[1])
                begin
                    roll  = $urandom_range(0, 9);
                    value = (roll == 0) ? 0 : (roll == 1) ? 1 : $urandom_range(2, 20);
                    value[CFG_DATA_W-1:COLS_CFG_W] = $urandom_range(0, 3);
                    write_reg(REG_FRAME_COLS, value);
                end
                if (mask[2])
                    write_reg(REG_BLOCK_HEIGHT, pick_block());
                if (mask[3])
                    write_reg(REG_BLOCK_WIDTH, pick_block());
                frames = $urandom_range(1, 3);
                extra  = ($urandom_range(0, 3) == 0) ?
                         $urandom_range(1, eff_rows * eff_cols) : 0;
                run_frames(frames, extra);
                ordinary_items += frames * eff_rows * eff_cols + extra;
            end
            settle();
        end

        if (means_due != 0)
            $display("%0d expected tile means never arrived", means_due);
        $display("Run covered %0d samples in %0d random phases after the directed tiles,",
                 samples_sent, phase);
        $display("with zero and oversize sizes and edge tiles; %0d tile means compared.",
                 means_checked);
        if (mismatch_count == 0 && means_due == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ block_average_downsampler.f @@
rtl/bavg_pkg.sv
rtl/block_average_downsampler.sv
tb/sv/block_average_downsampler_checker.sv
tb/sv/block_average_downsampler_tb.sv
